/* hw/rtl/npcm_pkg.sv */
package npcm_pkg;

  localparam int unsigned ChanW  = 12;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned SqW    = 2 * ChanW;
  localparam int unsigned DistW  = 26;
  localparam int unsigned PixW   = 8;

  localparam logic [ChanW-1:0]  PixMax      = 12'd255;
  localparam logic [CountW-1:0] CountReset  = 5'd12;

  typedef enum logic {
    CmdLoad     = 1'b0,
    CmdClassify = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [IdxW-1:0]  entry_index;
    logic [ChanW-1:0] chan_a;
    logic [ChanW-1:0] chan_b;
    logic [ChanW-1:0] chan_c;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IdxW-1:0]  best_index;
    logic [DistW-1:0] best_distance;
  } out_item_t;

  typedef struct packed {
    logic                  valid;
    cmd_e                  cmd;
    logic [IdxW-1:0]       entry_index;
    logic [2:0][ChanW-1:0] chan;
    logic                  have;
    logic [IdxW-1:0]       best_index;
    logic [DistW-1:0]      best_distance;
  } token_t;

endpackage

/* hw/rtl/npcm_cell.sv */
module npcm_cell import npcm_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [CountW-1:0] count_i,
  input  token_t            tok_i,
  output token_t            tok_o
);

  logic [2:0][ChanW-1:0] entry_q;
  token_t                mid_q;
  token_t                out_q;
  logic [2:0][SqW-1:0]   sq_d;
  logic [2:0][SqW-1:0]   sq_q;
  logic                  write_en;
  logic                  active;
  logic [DistW-1:0]      dist_sum;
  token_t                out_d;

  assign write_en = adv_i && tok_i.valid && (tok_i.cmd == CmdLoad)
                    && (32'(tok_i.entry_index) == 32'(CellIdx));
  assign active   = 32'(count_i) > 32'(CellIdx);

  always_comb begin
    logic [ChanW-1:0] diff;
    for (int k = 0; k < 3; k++) begin
      diff = (entry_q[k] >= tok_i.chan[k]) ? (entry_q[k] - tok_i.chan[k])
                                           : (tok_i.chan[k] - entry_q[k]);
      sq_d[k] = SqW'(diff) * SqW'(diff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_en) begin
      entry_q <= tok_i.chan;
    end
    if (adv_i) begin
      sq_q <= sq_d;
    end
  end

  assign dist_sum = DistW'(sq_q[0]) + DistW'(sq_q[1]) + DistW'(sq_q[2]);

  always_comb begin
    out_d = mid_q;
    if (mid_q.valid && (mid_q.cmd == CmdClassify) && active
        && (!mid_q.have || (dist_sum < mid_q.best_distance))) begin
      out_d.have          = 1'b1;
      out_d.best_index    = IdxW'(CellIdx);
      out_d.best_distance = dist_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      out_q <= '0;
    end else if (adv_i) begin
      mid_q <= tok_i;
      out_q <= out_d;
    end
  end

  assign tok_o = out_q;

endmodule

/* hw/rtl/nearest_palette_color_match_unit.sv */
// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o   in_item_t (load or classify)
// out      output     out_valid_o/out_stall_i out_item_t (classify results only)
// cfg      input      cfg_valid_i/cfg_ready_o palette count, 5 bits
//
// Each palette entry lives in its own cell; items pass each cell through its mid and out registers.
// One item is taken per cycle unless a stalled result freezes the chain. A result passes the input
// stage, each cell and the output register in turn, so its delay is set by the chain length.
// Reset clears all valid bits and sets the palette count to 12; entries are undefined until loaded.
// A stalled result freezes the whole chain; the input stage still fills while it is empty.
module nearest_palette_color_match_unit import npcm_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  logic [CountW-1:0] count_q;
  token_t            tok0_q;
  token_t            tok0_d;
  token_t            chain [MAX_ENTRIES+1];
  logic              adv;
  logic              in_acc;
  logic              out_valid_q;
  out_item_t         out_q;
  logic [2:0][ChanW-1:0] pix_in;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(adv || !tok0_q.valid);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pix_in[0] = in_data_i.chan_a;
  assign pix_in[1] = in_data_i.chan_b;
  assign pix_in[2] = in_data_i.chan_c;

  always_comb begin
    tok0_d = tok0_q;
    if (adv) begin
      tok0_d.valid = 1'b0;
    end
    if (in_acc) begin
      tok0_d.valid         = 1'b1;
      tok0_d.cmd           = in_data_i.cmd;
      tok0_d.entry_index   = in_data_i.entry_index;
      tok0_d.have          = 1'b0;
      tok0_d.best_index    = '0;
      tok0_d.best_distance = '0;
      for (int k = 0; k < 3; k++) begin
        if (in_data_i.cmd == CmdLoad) begin
          tok0_d.chan[k] = pix_in[k];
        end else if (pix_in[k] > PixMax) begin
          tok0_d.chan[k] = {PixMax[PixW-1:0], 4'b0000};
        end else begin
          tok0_d.chan[k] = {pix_in[k][PixW-1:0], 4'b0000};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= '0;
    end else begin
      tok0_q <= tok0_d;
    end
  end

  assign chain[0] = tok0_q;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    npcm_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .count_i(count_q),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain[MAX_ENTRIES].valid && (chain[MAX_ENTRIES].cmd == CmdClassify);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.found         <= chain[MAX_ENTRIES].have;
      out_q.best_index    <= chain[MAX_ENTRIES].best_index;
      out_q.best_distance <= chain[MAX_ENTRIES].best_distance;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      (out_data_o.best_index == '0) && (out_data_o.best_distance == '0))
    else $error("Result without a match carries non-zero fields.");

  a_zero_count_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (count_q == '0) |-> !out_data_o.found)
    else $error("Match reported with an empty palette.");

  a_frozen_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv && tok0_q.valid |=> tok0_q.valid && $stable(tok0_q))
    else $error("Input stage lost an item while the chain was frozen.");
`endif

endmodule
